### hw/rtl/aclfm_pkg.sv
package aclfm_pkg;

    localparam int RULE_SLOTS_DEF      = 16;
    localparam int VALUES_PER_RULE_DEF = 8;
    localparam int RULE_ID_W           = 8;

    localparam logic [1:0] OP_WR_HDR   = 2'd0;
    localparam logic [1:0] OP_WR_VAL   = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;

    localparam logic [2:0] KIND_EMPTY    = 3'd0;
    localparam logic [2:0] KIND_SRC_RNG  = 3'd1;
    localparam logic [2:0] KIND_DST_RNG  = 3'd2;
    localparam logic [2:0] KIND_TCP_IN   = 3'd3;
    localparam logic [2:0] KIND_TCP_NOT  = 3'd4;
    localparam logic [2:0] KIND_UDP_IN   = 3'd5;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef struct packed {
        logic        hdr_we;
        logic        val_we;
        logic [3:0]  rule_index;
        logic [2:0]  value_index;
        logic [2:0]  rule_kind;
        logic        rule_action;
        logic [3:0]  value_count;
        logic        layer;
        logic [31:0] word_a;
        logic [31:0] word_b;
    } wr_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  protocol;
        logic [15:0] dest_port;
        logic        layer;
    } pkt_t;

    typedef struct packed {
        logic clr;
        logic ev;
    } scan_t;

    typedef struct packed {
        logic                 found;
        logic                 verdict;
        logic [RULE_ID_W-1:0] idx;
    } res_t;

endpackage

### hw/rtl/aclfm_ram.sv
module aclfm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/aclfm_cell.sv
module aclfm_cell #(
    parameter int ID              = 0,
    parameter int VALUES_PER_RULE = 8,
    parameter int AW              = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  aclfm_pkg::wr_t   wr,
    input  aclfm_pkg::pkt_t  pkt,
    input  aclfm_pkg::scan_t scan,
    input  logic [AW-1:0]   rd_addr,
    input  logic [AW-1:0]   ev_idx,
    input  aclfm_pkg::res_t  prev,
    output aclfm_pkg::res_t  res
);
    import aclfm_pkg::*;

    localparam int IW = (RULE_ID_W > 4) ? RULE_ID_W : 4;

    logic [2:0]  kind_reg;
    logic        action_reg;
    logic        layer_reg;
    logic [3:0]  count_reg;
    logic        any_reg;
    logic        any_next;
    res_t        res_reg;
    res_t        res_next;
    logic        sel;
    logic        val_ok;
    logic        val_we;
    logic [31:0] vi_ext;
    logic [63:0] rdata;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] addr;
    logic        hit;
    logic        match;

    assign sel    = ({{(IW-4){1'b0}}, wr.rule_index} == IW'(ID));
    assign vi_ext = {29'd0, wr.value_index};
    assign val_ok = vi_ext < 32'(VALUES_PER_RULE);
    assign val_we = wr.val_we && sel && val_ok;

    aclfm_ram #(
        .WIDTH(64),
        .DEPTH(VALUES_PER_RULE)
    ) u_ram (
        .clk  (clk),
        .we   (val_we),
        .waddr(vi_ext[AW-1:0]),
        .wdata({wr.word_b, wr.word_a}),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    assign lo   = rdata[31:0];
    assign hi   = rdata[63:32];
    assign addr = (kind_reg == KIND_DST_RNG) ? pkt.dst : pkt.src;

    always_comb
    begin
        if (kind_reg == KIND_SRC_RNG || kind_reg == KIND_DST_RNG)
        begin
            hit = (addr != 32'd0) && (lo <= addr) && (addr <= hi);
        end
        else
        begin
            hit = (lo[15:0] == pkt.dest_port);
        end
        any_next = any_reg;
        if (scan.clr)
        begin
            any_next = 1'b0;
        end
        else if (scan.ev && (32'(ev_idx) < 32'(count_reg)) && hit)
        begin
            any_next = 1'b1;
        end
    end

    always_comb
    begin
        match = 1'b0;
        if (layer_reg == pkt.layer)
        begin
            case (kind_reg)
                KIND_SRC_RNG, KIND_DST_RNG: match = !layer_reg && any_reg;
                KIND_TCP_IN:  match = layer_reg && (pkt.protocol == PROTO_TCP) && any_reg;
                KIND_TCP_NOT: match = layer_reg && (pkt.protocol == PROTO_TCP) && !any_reg;
                KIND_UDP_IN:  match = layer_reg && (pkt.protocol == PROTO_UDP) && any_reg;
                default:      match = 1'b0;
            endcase
        end
        if (prev.found || !match)
        begin
            res_next = prev;
        end
        else
        begin
            res_next.found   = 1'b1;
            res_next.verdict = action_reg;
            res_next.idx     = RULE_ID_W'(ID);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_EMPTY;
            action_reg <= 1'b0;
            layer_reg  <= 1'b0;
            count_reg  <= 4'd0;
            any_reg    <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            if (wr.hdr_we && sel)
            begin
                kind_reg   <= wr.rule_kind;
                action_reg <= wr.rule_action;
                layer_reg  <= wr.layer;
                count_reg  <= wr.value_count;
            end
            any_reg <= any_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### hw/rtl/acl_first_match_classifier_unit.sv
// Channel  Dir  Signals                            Contents
// s        in   s_tvalid s_tready s_tdata s_tuser  one rule write or one packet to classify
// m        out  m_tvalid m_tready m_tdata          one verdict per input transfer
//
// A rule write goes straight from its transfer to the done state, which registers its result.
// A classify reads one value per cycle from
// every rule memory at once, then the verdict ripples through the row of rule cells.
// One item is in work at a time; a new transfer is taken while the last result waits.
// Reset clears all rule headers to empty; rule values are undefined until written.
module acl_first_match_classifier_unit #(
    parameter int RULE_SLOTS      = aclfm_pkg::RULE_SLOTS_DEF,
    parameter int VALUES_PER_RULE = aclfm_pkg::VALUES_PER_RULE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rule_index[3:0], value_index[6:4], rule_kind[9:7], rule_action[10],
    // value_count[14:11], layer[15], word_a[47:16], word_b[79:48],
    // protocol[87:80], dest_port[103:88]
    input  logic [103:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // verdict[0], matched[1], matched_rule[5:2], zero[7:6]
    output logic [7:0]   m_tdata
);
    import aclfm_pkg::*;

    localparam int AW = (VALUES_PER_RULE > 1) ? $clog2(VALUES_PER_RULE) : 1;
    localparam int CW = $clog2(RULE_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CHAIN,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] v_reg;
    logic          ev_reg;
    logic [AW-1:0] ev_idx_reg;
    logic [CW-1:0] chain_cnt_reg;
    logic          zero_reg;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    pkt_t          pkt_reg;
    wr_t           wr;
    scan_t         scan;
    logic          accept;
    res_t          chain [RULE_SLOTS+1];
    logic [31:0]   idx_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign wr.hdr_we      = accept && (s_tuser == OP_WR_HDR);
    assign wr.val_we      = accept && (s_tuser == OP_WR_VAL);
    assign wr.rule_index  = s_tdata[3:0];
    assign wr.value_index = s_tdata[6:4];
    assign wr.rule_kind   = s_tdata[9:7];
    assign wr.rule_action = s_tdata[10];
    assign wr.value_count = s_tdata[14:11];
    assign wr.layer       = s_tdata[15];
    assign wr.word_a      = s_tdata[47:16];
    assign wr.word_b      = s_tdata[79:48];

    assign scan.clr = accept && (s_tuser == OP_CLASSIFY);
    assign scan.ev  = ev_reg;

    assign chain[0] = '0;

    for (genvar i = 0; i < RULE_SLOTS; i++)
    begin : g_cell
        aclfm_cell #(
            .ID             (i),
            .VALUES_PER_RULE(VALUES_PER_RULE),
            .AW             (AW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr     (wr),
            .pkt    (pkt_reg),
            .scan   (scan),
            .rd_addr(v_reg),
            .ev_idx (ev_idx_reg),
            .prev   (chain[i]),
            .res    (chain[i+1])
        );
    end

    assign idx_ext = 32'(chain[RULE_SLOTS].idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v_reg         <= '0;
            ev_reg        <= 1'b0;
            ev_idx_reg    <= '0;
            chain_cnt_reg <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            pkt_reg       <= '0;
        end
        else
        begin
            ev_reg     <= (state_reg == ST_SCAN);
            ev_idx_reg <= v_reg;
            if (out_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser == OP_CLASSIFY)
                        begin
                            pkt_reg.src       <= s_tdata[47:16];
                            pkt_reg.dst       <= s_tdata[79:48];
                            pkt_reg.protocol  <= s_tdata[87:80];
                            pkt_reg.dest_port <= s_tdata[103:88];
                            pkt_reg.layer     <= s_tdata[15];
                            v_reg             <= '0;
                            zero_reg          <= 1'b0;
                            state_reg         <= ST_SCAN;
                        end
                        else
                        begin
                            zero_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (32'(v_reg) == 32'(VALUES_PER_RULE - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        v_reg <= v_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    chain_cnt_reg <= '0;
                    state_reg     <= ST_CHAIN;
                end
                ST_CHAIN:
                begin
                    if (chain_cnt_reg == CW'(RULE_SLOTS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        chain_cnt_reg <= chain_cnt_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (zero_reg || !chain[RULE_SLOTS].found)
                        begin
                            out_data_reg <= '0;
                        end
                        else
                        begin
                            out_data_reg <= {2'b00, idx_ext[3:0], 1'b1,
                                             chain[RULE_SLOTS].verdict};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_classify_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == OP_CLASSIFY) |=> (state_reg == ST_SCAN))
        else $error("classify transfer did not start the value scan");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser != OP_CLASSIFY) |=> (state_reg == ST_DONE && zero_reg))
        else $error("write transfer did not go straight to its result");

    a_nomatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[0] == 1'b0 && m_tdata[5:2] == 4'd0))
        else $error("result without a match carries a verdict or index");

endmodule
